[rtl/capn_pkg.sv]
`default_nettype none

package capn_pkg;

	localparam logic [7:0] BASE_DEC = 8'd10;
	localparam logic [7:0] BASE_HEX = 8'd16;
	localparam logic [7:0] BASE_RESET = BASE_DEC;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_LC_A = 8'h61;
	localparam logic [7:0] CHAR_LC_F = 8'h66;
	localparam logic [7:0] CHAR_UC_A = 8'h41;
	localparam logic [7:0] CHAR_UC_F = 8'h46;
	localparam logic [7:0] CHAR_LC_X = 8'h78;
	localparam logic [7:0] CHAR_UC_X = 8'h58;

	localparam logic [31:0] VALUE_SAT = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_PREFIX = 2'd1,
		ST_DIGIT  = 2'd2,
		ST_BASE   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_LATER  = 2'd2
	} pos_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} item_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			v = {1'b0, c[3:0]};
		end else if ((c >= CHAR_LC_A && c <= CHAR_LC_F) || (c >= CHAR_UC_A && c <= CHAR_UC_F)) begin
			v = {1'b0, c[3:0] + 4'd9};
		end
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/checked_ascii_number_parser_top.sv]
`default_nettype none

// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tdata[7:0] char_code, tlast last_char
// m_*       out  m_tvalid/m_tready    tdata[31:0] parsed_value, tuser[1:0] parse_status
// cfg_*     in   cfg_valid/cfg_ready  cfg_data[7:0] number_base
//
// One character per cycle sustained while the result channel is not stalled; a result
// passes the input register and then the result register around the multiply-add.
// Only the last character of a string yields a result item.
// Reset clears the per-string state and sets number_base to 10.
// A stalled result blocks only the last character of the next string.

module checked_ascii_number_parser_top
	import capn_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // last_char
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] parsed_value
	output logic [1:0]       m_tuser,   // [1:0] parse_status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data   // [7:0] number_base
);

	logic [7:0] base_q;
	logic       take;
	logic       valid_s1;
	item_t      item_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	capn_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	capn_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.number_base (base_q),
		.in_valid    (valid_s1),
		.in_item     (item_s1),
		.take        (take),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

endmodule

`default_nettype wire

[rtl/capn_in_reg.sv]
`default_nettype none

module capn_in_reg
	import capn_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] char_code
	input  wire logic       s_tlast,   // last_char
	input  wire logic       take,
	output logic            valid_s1,
	output item_t           item_s1
);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.char_code <= s_tdata;
			item_s1.last_char <= s_tlast;
		end
	end

endmodule

`default_nettype wire

[rtl/capn_core.sv]
`default_nettype none

module capn_core
	import capn_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  number_base,
	input  wire logic        in_valid,
	input  wire item_t       in_item,
	output logic             take,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] parsed_value
	output logic [1:0]       m_tuser    // [1:0] parse_status
);

	pos_t        pos_q;
	logic [31:0] acc_q;
	logic        ovf_q;
	logic        lead0_q;
	logic        bad_q;
	logic        pfx_q;

	pos_t        pos_n;
	logic [31:0] acc_n;
	logic        ovf_n;
	logic        lead0_n;
	logic        bad_n;
	logic        pfx_n;

	logic [7:0]  c;
	logic        base10;
	logic        base16;
	logic        is_dec;
	logic [4:0]  hv;
	logic        is_prefix;
	logic        do_acc;
	logic [3:0]  dig;
	logic [35:0] prod;
	logic [35:0] sum;
	status_t     status;
	logic [31:0] value;

	always_comb begin
		c = in_item.char_code;
		base10 = (number_base == BASE_DEC);
		base16 = (number_base == BASE_HEX);
		is_dec = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		hv = hex_value(c);
		is_prefix = base16 && (pos_q == POS_SECOND) && (c == CHAR_LC_X || c == CHAR_UC_X);

		lead0_n = (pos_q == POS_FIRST) ? (c == CHAR_ZERO) : lead0_q;

		do_acc = 1'b0;
		dig = 4'd0;
		bad_n = bad_q;
		pfx_n = pfx_q;
		if (base10) begin
			do_acc = is_dec;
			dig = c[3:0];
			bad_n = bad_q || !is_dec;
		end else if (base16) begin
			if (is_prefix) begin
				pfx_n = pfx_q || !lead0_q;
			end else begin
				do_acc = !hv[4];
				dig = hv[3:0];
				bad_n = bad_q || hv[4];
			end
		end

		// x10 as x8 + x2, x16 as a shift
		prod = base10 ? ({acc_q, 3'b000} + {3'b000, acc_q, 1'b0}) : {acc_q, 4'b0000};
		sum = prod + {32'd0, dig};
		acc_n = acc_q;
		ovf_n = ovf_q;
		if (do_acc) begin
			if (|sum[35:32]) begin
				acc_n = VALUE_SAT;
				ovf_n = 1'b1;
			end else begin
				acc_n = sum[31:0];
			end
		end

		pos_n = (pos_q == POS_FIRST) ? POS_SECOND : POS_LATER;

		if (!base10 && !base16) begin
			status = ST_BASE;
		end else if (pfx_n) begin
			status = ST_PREFIX;
		end else if (bad_n) begin
			status = ST_DIGIT;
		end else begin
			status = ST_OK;
		end
		value = (status != ST_OK) ? 32'd0 : (ovf_n ? VALUE_SAT : acc_n);
	end

	assign take = in_valid && (!in_item.last_char || !m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_FIRST;
			acc_q <= 32'd0;
			ovf_q <= 1'b0;
			lead0_q <= 1'b0;
			bad_q <= 1'b0;
			pfx_q <= 1'b0;
		end else if (take) begin
			if (in_item.last_char) begin
				pos_q <= POS_FIRST;
				acc_q <= 32'd0;
				ovf_q <= 1'b0;
				lead0_q <= 1'b0;
				bad_q <= 1'b0;
				pfx_q <= 1'b0;
			end else begin
				pos_q <= pos_n;
				acc_q <= acc_n;
				ovf_q <= ovf_n;
				lead0_q <= lead0_n;
				bad_q <= bad_n;
				pfx_q <= pfx_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (take && in_item.last_char) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_item.last_char) begin
			m_tdata <= value;
			m_tuser <= status;
		end
	end

endmodule

`default_nettype wire

[sim/tb.sv]
`default_nettype none

module tb;
	import capn_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 6;
	localparam int PHASE_ITEMS    = 200;
	localparam int HOLD_CYCLES    = 400;
	localparam int N_ROWS         = 33;

	typedef enum logic {ROW_CHAR, ROW_BASE} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  data;
		logic        last;
		logic        typed;
		logic [31:0] value;
		status_t     status;
	} dir_row_t;

	typedef struct packed {
		logic [31:0] value;
		status_t     status;
	} parse_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [7:0] char_code
	logic        s_tlast = 1'b0;   // last_char
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // [31:0] parsed_value
	logic [1:0]  m_tuser;          // [1:0] parse_status
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'd0;  // [7:0] number_base

	checked_ascii_number_parser_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// predictor state
	logic [7:0]  base_reg = BASE_RESET;
	logic [31:0] acc = 32'd0;
	logic        ovf = 1'b0;
	pos_t        pos = POS_FIRST;
	logic        lead_zero = 1'b0;
	logic        bad_digit = 1'b0;
	logic        bad_prefix = 1'b0;

	parse_result_t pending_results[$];
	logic [7:0]    str_buf[$];
	int            n_errors = 0;
	int            src_idle_pct = 0;
	int            rcv_idle_pct = 0;
	int            hold_len = 0;
	int            idle_count = 0;
	int            phase_items = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic parse_char(input logic [7:0] c, input logic l,
			output logic emit, output parse_result_t res);
		logic [4:0]  dv;
		logic        is_digit;
		logic [63:0] wide;
		emit = l;
		res = '0;
		dv = 5'd0;
		is_digit = 1'b0;
		if (pos == POS_FIRST)
			lead_zero = (c == CHAR_ZERO);
		if (base_reg == BASE_DEC) begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				is_digit = 1'b1;
				dv = 5'(c - CHAR_ZERO);
			end else begin
				bad_digit = 1'b1;
			end
		end else if (base_reg == BASE_HEX) begin
			if (pos == POS_SECOND && (c == CHAR_LC_X || c == CHAR_UC_X)) begin
				if (!lead_zero)
					bad_prefix = 1'b1;
			end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				is_digit = 1'b1;
				dv = 5'(c - CHAR_ZERO);
			end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
				is_digit = 1'b1;
				dv = 5'(c - CHAR_LC_A + 8'd10);
			end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
				is_digit = 1'b1;
				dv = 5'(c - CHAR_UC_A + 8'd10);
			end else begin
				bad_digit = 1'b1;
			end
		end
		if (is_digit) begin
			wide = 64'(acc) * 64'(base_reg) + 64'(dv);
			if (wide > 64'(VALUE_SAT)) begin
				ovf = 1'b1;
				acc = VALUE_SAT;
			end else begin
				acc = wide[31:0];
			end
		end
		if (pos != POS_LATER)
			pos = pos_t'(pos + 2'd1);
		if (l) begin
			if (base_reg != BASE_DEC && base_reg != BASE_HEX)
				res.status = ST_BASE;
			else if (bad_prefix)
				res.status = ST_PREFIX;
			else if (bad_digit)
				res.status = ST_DIGIT;
			else
				res.status = ST_OK;
			res.value = (res.status != ST_OK) ? 32'd0 : (ovf ? VALUE_SAT : acc);
			acc = 32'd0;
			ovf = 1'b0;
			pos = POS_FIRST;
			lead_zero = 1'b0;
			bad_digit = 1'b0;
			bad_prefix = 1'b0;
		end
	endtask

	task automatic send_char(input logic [7:0] c, input logic l, input logic typed,
			input parse_result_t typed_res);
		logic          emit;
		parse_result_t res;
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
		parse_char(c, l, emit, res);
		if (emit)
			pending_results.push_back(typed ? typed_res : res);
		phase_items++;
	endtask

	task automatic write_base(input logic [7:0] b);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= b;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_reg = b;
	endtask

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(21);
		if (v < 10)
			return CHAR_ZERO + 8'(v);
		else if (v < 16)
			return CHAR_LC_A + 8'(v - 10);
		return CHAR_UC_A + 8'(v - 16);
	endfunction

	// mostly well-formed strings for the base, some corrupted, some noise
	task automatic build_string(input logic [7:0] b);
		int roll;
		int n;
		str_buf.delete();
		roll = $urandom_range(99);
		if (roll < 15) begin
			n = $urandom_range(6, 1);
			repeat (n) str_buf.push_back(8'($urandom_range(255)));
		end else begin
			if (b == BASE_HEX || (b != BASE_DEC && $urandom_range(1) == 1)) begin
				if ($urandom_range(1) == 1) begin
					str_buf.push_back(CHAR_ZERO);
					str_buf.push_back($urandom_range(1) == 1 ? CHAR_LC_X : CHAR_UC_X);
				end
				n = $urandom_range(10, 1);
				repeat (n) str_buf.push_back(hex_char());
			end else begin
				n = $urandom_range(11, 1);
				repeat (n) str_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
			end
			if (roll >= 85)
				str_buf[$urandom_range(str_buf.size() - 1)] = 8'($urandom_range(255));
		end
	endtask

	// receiver side
	initial begin
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result: value %0h status %0d", m_tdata, m_tuser);
			end else begin
				if (m_tdata !== pending_results[0].value ||
						m_tuser !== pending_results[0].status) begin
					n_errors++;
					if (n_errors <= 10)
						$display("mismatch: expected value %0h status %0d, got %0h status %0d",
							pending_results[0].value, pending_results[0].status,
							m_tdata, m_tuser);
				end
				void'(pending_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		dir_row_t      dir_table [N_ROWS];
		parse_result_t typed_res;
		int            n;
		logic [7:0]    b;
		dir_table = '{
			'{ROW_CHAR, "9",   1'b1, 1'b1, 32'd9,      ST_OK},
			'{ROW_CHAR, 8'h00, 1'b1, 1'b1, 32'd0,      ST_DIGIT},
			'{ROW_CHAR, 8'hFF, 1'b1, 1'b1, 32'd0,      ST_DIGIT},
			'{ROW_BASE, BASE_HEX, 1'b0, 1'b0, 32'd0,   ST_OK},
			'{ROW_CHAR, "0",   1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_CHAR, "x",   1'b1, 1'b1, 32'd0,      ST_OK},
			'{ROW_CHAR, "1",   1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_CHAR, "x",   1'b1, 1'b1, 32'd0,      ST_PREFIX},
			'{ROW_CHAR, "1",   1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_CHAR, "X",   1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_CHAR, "g",   1'b1, 1'b1, 32'd0,      ST_PREFIX},
			'{ROW_CHAR, "x",   1'b1, 1'b1, 32'd0,      ST_DIGIT},
			'{ROW_CHAR, "1",   1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_CHAR, "F",   1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_CHAR, "f",   1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_CHAR, "F",   1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_CHAR, "f",   1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_CHAR, "F",   1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_CHAR, "f",   1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_CHAR, "F",   1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_CHAR, "f",   1'b1, 1'b1, VALUE_SAT,  ST_OK},
			'{ROW_BASE, 8'd0,  1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_CHAR, "5",   1'b1, 1'b1, 32'd0,      ST_BASE},
			'{ROW_BASE, 8'd255, 1'b0, 1'b0, 32'd0,     ST_OK},
			'{ROW_CHAR, "x",   1'b1, 1'b1, 32'd0,      ST_BASE},
			'{ROW_BASE, BASE_DEC, 1'b0, 1'b0, 32'd0,   ST_OK},
			'{ROW_CHAR, "1",   1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_BASE, BASE_HEX, 1'b0, 1'b0, 32'd0,   ST_OK},
			'{ROW_CHAR, "f",   1'b1, 1'b0, 32'd0,      ST_OK},
			'{ROW_BASE, 8'd7,  1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_CHAR, "3",   1'b0, 1'b0, 32'd0,      ST_OK},
			'{ROW_BASE, BASE_DEC, 1'b0, 1'b0, 32'd0,   ST_OK},
			'{ROW_CHAR, "4",   1'b1, 1'b0, 32'd0,      ST_OK}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, with idling as in the first random mode
		src_idle_pct = 28;
		rcv_idle_pct = 65;
		for (int r = 0; r < N_ROWS; r++) begin
			if (dir_table[r].kind == ROW_BASE) begin
				write_base(dir_table[r].data);
			end else begin
				typed_res.value = dir_table[r].value;
				typed_res.status = dir_table[r].status;
				send_char(dir_table[r].data, dir_table[r].last, dir_table[r].typed, typed_res);
			end
		end

		for (int ph = 0; ph < 9; ph++) begin
			case (ph / 3)
				0: begin
					src_idle_pct = 28;
					rcv_idle_pct = 65;
				end
				1: begin
					src_idle_pct = 65;
					rcv_idle_pct = 28;
				end
				default: begin
					src_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			case (ph)
				0: b = BASE_DEC;
				1: b = BASE_HEX;
				2: b = 8'($urandom_range(255));
				3: b = BASE_HEX;
				4: b = 8'd0;
				5: b = BASE_DEC;
				6: b = BASE_HEX;
				7: b = 8'd255;
				default: b = BASE_DEC;
			endcase
			write_base(b);
			if (ph == 6)
				hold_len = HOLD_CYCLES;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				build_string(base_reg);
				n = str_buf.size();
				for (int i = 0; i < n; i++)
					send_char(str_buf[i], i == n - 1, 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
rtl/capn_pkg.sv
rtl/capn_in_reg.sv
rtl/capn_core.sv
rtl/checked_ascii_number_parser_top.sv
sim/tb.sv
